### rtl/grc_pkg.sv
`timescale 1ns / 1ps

package grc_pkg;

	localparam int GRID_WIDTH_DEF  = 256;
	localparam int GRID_HEIGHT_DEF = 256;

	// signed ray coordinates and unsigned step counts
	localparam int CW = 17;
	// bresenham error term
	localparam int EW = CW + 2;
	localparam int DW = 18;
	localparam logic [DW-1:0] DIST_MAX = 18'h3FFFF;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 9;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_LOADED    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_IN_USE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_IN_USE = 2'd2;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_RAY   = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_PUSH
	} state_t;

endpackage

### rtl/grc_ram.sv
`timescale 1ns / 1ps

module grc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### rtl/grid_ray_cast.sv
`timescale 1ns / 1ps

// Occupancy grid ray caster.
// The input channel carries two kinds of word. A write word (action 0) stores
// one cell of the grid, occupied when occupancy is above zero, and gives no
// result. A ray word (action 1) walks the bresenham line
// from start to end cell and gives one result word: hit, stopping cell and
// squared distance, or all zero when the ray runs free or the map is not
// loaded. The config channel writes map_loaded, width_in_use, height_in_use
// and is always ready; write it only while the block is idle.
// A ray reads one cell a cycle from the single-port grid memory, with the
// check of each cell in the cycle after its read.
// One ray is in flight at a time. The output register holds a finished word
// while the receiver stalls and the block takes the next word; a second ray
// that finishes meanwhile waits until the output register is free.
// Reset clears control and config registers but not the grid memory, which
// holds garbage until written; rays must only visit cells already written.
module grid_ray_cast #(
	parameter int GRID_WIDTH  = grc_pkg::GRID_WIDTH_DEF,
	parameter int GRID_HEIGHT = grc_pkg::GRID_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,

	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [7:0]                     cell_x,
	input  logic [7:0]                     cell_y,
	input  logic signed [7:0]              occupancy,
	input  logic signed [15:0]             start_x,
	input  logic signed [15:0]             start_y,
	input  logic signed [15:0]             end_x,
	input  logic signed [15:0]             end_y,

	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic signed [15:0]             hit_x,
	output logic signed [15:0]             hit_y,
	output logic [grc_pkg::DW-1:0]         distance_squared,

	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [grc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [grc_pkg::CFG_DAT_W-1:0]  cfg_data
);

	import grc_pkg::*;

	localparam int DEPTH = GRID_WIDTH * GRID_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam logic [CW-1:0] GW = CW'(GRID_WIDTH);
	localparam logic [CW-1:0] GH = CW'(GRID_HEIGHT);

	state_t state_q, state_d;

	logic           loaded_q;
	logic [8:0]     wiu_q, hiu_q;

	// walk front: the cell whose read is issued this cycle
	logic           issue_q;
	logic signed [CW-1:0] maj_q, min_q;
	logic signed [EW-1:0] err_q;
	logic [CW-1:0]  icnt_q, mcnt_q, dx_q, dy_q;
	logic           maj_neg_q, min_neg_q, steep_q;

	// cell under check, its memory data arrives this cycle
	logic           valid_s1;
	logic signed [CW-1:0] cx_s1, cy_s1;
	logic [CW-1:0]  i_s1, m_s1;
	logic           oob_s1, last_s1;

	logic           pend_hit_q;
	logic [15:0]    pend_x_q, pend_y_q;
	logic [DW-1:0]  pend_d_q;

	logic           out_valid_q, hit_q;
	logic [15:0]    hit_x_q, hit_y_q;
	logic [DW-1:0]  dist_q;

	logic           mem_we, mem_wdata, mem_rdata;
	logic [AW-1:0]  mem_addr;
	logic [CW-1:0]  row, col;

	logic           ray_acc, wr_acc, slot_free, finish, stop_s1, last_cur, oob_cur;
	logic           walk_sel;

	// ray setup from the input word
	logic signed [CW-1:0] sx, sy, ex, ey, a0, b0, a1, b1;
	logic signed [CW:0]   ddx, ddy;
	logic [CW-1:0]  adx, ady;
	logic           steep_in;

	always_comb begin
		sx = CW'(start_x);
		sy = CW'(start_y);
		ex = CW'(end_x);
		ey = CW'(end_y);
		ddx = (CW+1)'(ex) - (CW+1)'(sx);
		ddy = (CW+1)'(ey) - (CW+1)'(sy);
		adx = ddx[CW] ? CW'(-ddx) : ddx[CW-1:0];
		ady = ddy[CW] ? CW'(-ddy) : ddy[CW-1:0];
		steep_in = ady > adx;
		a0 = steep_in ? sy : sx;
		b0 = steep_in ? sx : sy;
		a1 = steep_in ? ey : ex;
		b1 = steep_in ? ex : ey;
	end

	// current cell and next step
	logic signed [CW-1:0] cx_cur, cy_cur;
	logic [CW-1:0]  eff_w, eff_h;
	logic signed [EW-1:0] e_add;
	logic           step_min;

	always_comb begin
		cx_cur = steep_q ? min_q : maj_q;
		cy_cur = steep_q ? maj_q : min_q;
		eff_w = (CW'(wiu_q) > GW) ? GW : CW'(wiu_q);
		eff_h = (CW'(hiu_q) > GH) ? GH : CW'(hiu_q);
		oob_cur = cx_cur[CW-1] || cy_cur[CW-1] ||
			($unsigned(cx_cur) >= eff_w) || ($unsigned(cy_cur) >= eff_h);
		last_cur = icnt_q == dx_q;
		e_add = err_q + EW'(dy_q);
		step_min = $signed({e_add, 1'b0}) >= $signed({3'b000, dx_q});
	end

	// distance: any step count above 511 already saturates
	logic [17:0]    sq_i, sq_m;
	logic [18:0]    sq_sum;
	logic [DW-1:0]  dist_s1;

	always_comb begin
		sq_i = i_s1[8:0] * i_s1[8:0];
		sq_m = m_s1[8:0] * m_s1[8:0];
		sq_sum = 19'(sq_i) + 19'(sq_m);
		if ((i_s1[CW-1:9] != '0) || (m_s1[CW-1:9] != '0) || sq_sum[18]) begin
			dist_s1 = DIST_MAX;
		end else begin
			dist_s1 = sq_sum[DW-1:0];
		end
	end

	assign stop_s1   = oob_s1 || mem_rdata;
	assign finish    = valid_s1 && (stop_s1 || last_s1);
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		walk_sel = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && action == ACT_RAY) begin
					state_d = loaded_q ? ST_WALK : ST_PUSH;
				end
			end
			ST_WALK: begin
				walk_sel = 1'b1;
				if (finish) begin
					state_d = ST_PUSH;
				end
			end
			ST_PUSH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign ray_acc = in_valid && in_ready && action == ACT_RAY;
	assign wr_acc  = in_valid && in_ready && action == ACT_WRITE;

	// one address port: walk cell while walking, write cell otherwise
	always_comb begin
		row = walk_sel ? $unsigned(cy_cur) : CW'(cell_y);
		col = walk_sel ? $unsigned(cx_cur) : CW'(cell_x);
		mem_addr  = AW'(row) * AW'(GRID_WIDTH) + AW'(col);
		mem_we    = wr_acc && (CW'(cell_x) < GW) && (CW'(cell_y) < GH);
		mem_wdata = !occupancy[7] && (occupancy != '0);
	end

	grc_ram #(
		.WIDTH (1),
		.DEPTH (DEPTH)
	) u_grid (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= 1'b0;
			wiu_q    <= 9'd256;
			hiu_q    <= 9'd256;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAP_LOADED:    loaded_q <= cfg_data[0];
				CFG_WIDTH_IN_USE:  wiu_q    <= cfg_data;
				CFG_HEIGHT_IN_USE: hiu_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else if (ray_acc) begin
			issue_q  <= loaded_q;
			valid_s1 <= 1'b0;
		end else if (state_q == ST_WALK) begin
			if (finish) begin
				issue_q  <= 1'b0;
				valid_s1 <= 1'b0;
			end else begin
				valid_s1 <= issue_q;
				if (issue_q && last_cur) begin
					issue_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ray_acc) begin
			maj_q     <= a0;
			min_q     <= b0;
			err_q     <= '0;
			icnt_q    <= '0;
			mcnt_q    <= '0;
			dx_q      <= steep_in ? ady : adx;
			dy_q      <= steep_in ? adx : ady;
			maj_neg_q <= !(a0 < a1);
			min_neg_q <= !(b0 < b1);
			steep_q   <= steep_in;
		end else if (state_q == ST_WALK && issue_q && !last_cur) begin
			maj_q  <= maj_neg_q ? maj_q - CW'(1) : maj_q + CW'(1);
			icnt_q <= icnt_q + CW'(1);
			if (step_min) begin
				min_q  <= min_neg_q ? min_q - CW'(1) : min_q + CW'(1);
				mcnt_q <= mcnt_q + CW'(1);
				err_q  <= e_add - EW'(dx_q);
			end else begin
				err_q <= e_add;
			end
		end
		if (state_q == ST_WALK && issue_q) begin
			cx_s1   <= cx_cur;
			cy_s1   <= cy_cur;
			i_s1    <= icnt_q;
			m_s1    <= mcnt_q;
			oob_s1  <= oob_cur;
			last_s1 <= last_cur;
		end
	end

	always_ff @(posedge clk) begin
		if (ray_acc || (finish && !stop_s1)) begin
			pend_hit_q <= 1'b0;
			pend_x_q   <= '0;
			pend_y_q   <= '0;
			pend_d_q   <= '0;
		end else if (finish) begin
			pend_hit_q <= 1'b1;
			pend_x_q   <= cx_s1[15:0];
			pend_y_q   <= cy_s1[15:0];
			pend_d_q   <= dist_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_PUSH && slot_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_PUSH && slot_free) begin
			hit_q   <= pend_hit_q;
			hit_x_q <= pend_x_q;
			hit_y_q <= pend_y_q;
			dist_q  <= pend_d_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign hit              = hit_q;
	assign hit_x            = hit_x_q;
	assign hit_y            = hit_y_q;
	assign distance_squared = dist_q;

	a_s1_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> state_q == ST_WALK)
		else $error("cell check outside walk");

	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !mem_we)
		else $error("grid written during a ray");

	a_finish_push: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && finish) |=> state_q == ST_PUSH)
		else $error("finished ray not pushed");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !hit) |-> (hit_x == '0 && hit_y == '0 && distance_squared == '0))
		else $error("miss word carries nonzero fields");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import grc_pkg::*;

	localparam int GW = GRID_WIDTH_DEF;
	localparam int GH = GRID_HEIGHT_DEF;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int SEG_WORDS = 150;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic              action;
		logic [7:0]        cell_x;
		logic [7:0]        cell_y;
		logic signed [7:0] occupancy;
		logic signed [15:0] start_x;
		logic signed [15:0] start_y;
		logic signed [15:0] end_x;
		logic signed [15:0] end_y;
	} grid_word_t;

	typedef struct packed {
		logic               hit;
		logic signed [15:0] hit_x;
		logic signed [15:0] hit_y;
		logic [DW-1:0]      dist_sq;
	} ray_result_t;

	class ray_scoreboard;
		bit          cell_occ [GW*GH];
		bit          cell_known [GW*GH];
		bit          loaded;
		int unsigned cols_used;
		int unsigned rows_used;
		ray_result_t due [$];
		int          mismatches;
		int          rays_seen;
		int          hits_seen;

		function new();
			loaded = 1'b0;
			cols_used = 256;
			rows_used = 256;
			mismatches = 0;
			rays_seen = 0;
			hits_seen = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
			case (idx)
				CFG_MAP_LOADED:    loaded = data[0];
				CFG_WIDTH_IN_USE:  cols_used = data;
				CFG_HEIGHT_IN_USE: rows_used = data;
				default: ;
			endcase
		endfunction

		// bresenham walk; with probe set it returns early at the first grid cell
		// on the path that has never been written
		function void trace(input logic signed [15:0] sx, sy, ex, ey, input bit probe,
				output bit stop, output int hx, hy, output longint dsq, output int gap);
			int x0, y0, x1, y1, x, y, t, dx, dy, xs, ys, cx, cy, i, wc, hr;
			longint err;
			bit steep;
			wc = (cols_used > GW) ? GW : int'(cols_used);
			hr = (rows_used > GH) ? GH : int'(rows_used);
			x0 = sx;
			y0 = sy;
			x1 = ex;
			y1 = ey;
			dx = (x1 > x0) ? x1 - x0 : x0 - x1;
			dy = (y1 > y0) ? y1 - y0 : y0 - y1;
			steep = dy > dx;
			if (steep) begin
				t = x0; x0 = y0; y0 = t;
				t = x1; x1 = y1; y1 = t;
				t = dx; dx = dy; dy = t;
			end
			xs = (x0 < x1) ? 1 : -1;
			ys = (y0 < y1) ? 1 : -1;
			x = x0;
			y = y0;
			err = 0;
			i = 0;
			stop = 1'b0;
			gap = -1;
			hx = 0;
			hy = 0;
			dsq = 0;
			cx = 0;
			cy = 0;
			forever begin
				if (i > 0) begin
					x += xs;
					err += dy;
					if (2 * err >= dx) begin
						y += ys;
						err -= dx;
					end
				end
				cx = steep ? y : x;
				cy = steep ? x : y;
				if (probe && cx >= 0 && cy >= 0 && cx < GW && cy < GH
						&& !cell_known[cy * GW + cx]) begin
					gap = cy * GW + cx;
					return;
				end
				if (cx < 0 || cy < 0 || cx >= wc || cy >= hr || cell_occ[cy * GW + cx]) begin
					stop = 1'b1;
					break;
				end
				if (i >= dx)
					break;
				i++;
			end
			if (stop) begin
				hx = cx;
				hy = cy;
				dsq = longint'(x - x0) * (x - x0) + longint'(y - y0) * (y - y0);
			end
		endfunction

		function void note_word(grid_word_t w);
			ray_result_t want;
			bit stop;
			int hx, hy, gap, idx;
			longint dsq;
			if (w.action == ACT_WRITE) begin
				idx = int'(w.cell_y) * GW + int'(w.cell_x);
				cell_occ[idx] = (w.occupancy > 0);
				cell_known[idx] = 1'b1;
				return;
			end
			want = '0;
			if (loaded) begin
				trace(w.start_x, w.start_y, w.end_x, w.end_y, 1'b0, stop, hx, hy, dsq, gap);
				if (stop) begin
					want.hit = 1'b1;
					want.hit_x = 16'(hx);
					want.hit_y = 16'(hy);
					want.dist_sq = (dsq > DIST_MAX) ? DIST_MAX : dsq[DW-1:0];
				end
			end
			due.push_back(want);
		endfunction

		task report(input string msg);
			mismatches++;
			if (mismatches <= 40)
				$display("mismatch at %0t: %s", $time, msg);
		endtask

		task check_result(input ray_result_t got);
			ray_result_t want;
			if (due.size() == 0) begin
				report($sformatf("result word with nothing pending: hit %0b (%0d,%0d) d2 %0d",
					got.hit, got.hit_x, got.hit_y, got.dist_sq));
				return;
			end
			want = due.pop_front();
			rays_seen++;
			if (want.hit)
				hits_seen++;
			if (got.hit !== want.hit)
				report($sformatf("ray %0d hit %0b, want %0b", rays_seen, got.hit, want.hit));
			if (got.hit_x !== want.hit_x)
				report($sformatf("ray %0d hit_x %0d, want %0d", rays_seen, got.hit_x, want.hit_x));
			if (got.hit_y !== want.hit_y)
				report($sformatf("ray %0d hit_y %0d, want %0d", rays_seen, got.hit_y, want.hit_y));
			if (got.dist_sq !== want.dist_sq)
				report($sformatf("ray %0d distance_squared %0d, want %0d",
					rays_seen, got.dist_sq, want.dist_sq));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic in_valid = 1'b0;
	logic in_ready;
	logic action = ACT_WRITE;
	logic [7:0] cell_x = '0;
	logic [7:0] cell_y = '0;
	logic signed [7:0] occupancy = '0;
	logic signed [15:0] start_x = '0;
	logic signed [15:0] start_y = '0;
	logic signed [15:0] end_x = '0;
	logic signed [15:0] end_y = '0;

	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;
	logic signed [15:0] hit_x;
	logic signed [15:0] hit_y;
	logic [DW-1:0] distance_squared;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	ray_scoreboard sb;
	int in_idle = 0;
	int out_idle = 0;
	int words_sent = 0;
	int cycles = 0;

	grid_ray_cast DUT (.*);

	initial forever #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result({hit, hit_x, hit_y, distance_squared});
		out_ready <= ($urandom_range(99) >= out_idle);
	end

	function automatic logic signed [7:0] pick_occ();
		// mostly free cells so that rays walk a fair distance
		if ($urandom_range(99) < 4)
			return 8'($urandom_range(127, 1));
		return 8'(-int'($urandom_range(128)));
	endfunction

	// fields that the word's action does not use carry random values
	function automatic grid_word_t noise_word();
		grid_word_t w;
		w.action = 1'($urandom);
		w.cell_x = 8'($urandom);
		w.cell_y = 8'($urandom);
		w.occupancy = 8'($urandom);
		w.start_x = 16'($urandom);
		w.start_y = 16'($urandom);
		w.end_x = 16'($urandom);
		w.end_y = 16'($urandom);
		return w;
	endfunction

	task automatic send_word(input grid_word_t w);
		if ($urandom_range(99) < in_idle) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < in_idle);
		end
		in_valid <= 1'b1;
		action <= w.action;
		cell_x <= w.cell_x;
		cell_y <= w.cell_y;
		occupancy <= w.occupancy;
		start_x <= w.start_x;
		start_y <= w.start_y;
		end_x <= w.end_x;
		end_y <= w.end_y;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_word(w);
		words_sent++;
	endtask

	task automatic send_write(input logic [7:0] x, y, input logic signed [7:0] occ);
		grid_word_t w;
		w = noise_word();
		w.action = ACT_WRITE;
		w.cell_x = x;
		w.cell_y = y;
		w.occupancy = occ;
		send_word(w);
	endtask

	// every grid cell the ray will read gets written first
	task automatic cast_ray(input logic signed [15:0] sx, sy, ex, ey);
		grid_word_t w;
		bit stop;
		int hx, hy, gap;
		longint dsq;
		if (sb.loaded) begin
			sb.trace(sx, sy, ex, ey, 1'b1, stop, hx, hy, dsq, gap);
			while (gap >= 0) begin
				send_write(8'(gap % GW), 8'(gap / GW), pick_occ());
				sb.trace(sx, sy, ex, ey, 1'b1, stop, hx, hy, dsq, gap);
			end
		end
		w = noise_word();
		w.action = ACT_RAY;
		w.start_x = sx;
		w.start_y = sy;
		w.end_x = ex;
		w.end_y = ey;
		send_word(w);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(idx, data);
	endtask

	task automatic set_grid_cfg(input bit ld, input int unsigned cols, rows);
		write_reg(CFG_MAP_LOADED, {8'($urandom), ld});
		write_reg(CFG_WIDTH_IN_USE, 9'(cols));
		write_reg(CFG_HEIGHT_IN_USE, 9'(rows));
		write_reg(CFG_SPARE, 9'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// drain all pending results, then give trailing grid writes time to land
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	initial begin
		bit ld;
		int unsigned cols, rows, ec, er, pick, goal;
		logic signed [15:0] sx, sy, ex, ey;
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// map not loaded after reset: every ray answers all zero
		cast_ray(16'sd5, 16'sd5, 16'sd9, 16'sd7);
		cast_ray(-16'sd32768, 16'sd32767, 16'sd0, 16'sd0);
		settle();
		set_grid_cfg(1'b1, 256, 256);

		send_write(8'd0, 8'd0, 8'sd127);
		send_write(8'd255, 8'd255, -8'sd128);
		send_write(8'd0, 8'd255, 8'sd0);
		// zero-length ray on an occupied cell
		cast_ray(16'sd0, 16'sd0, 16'sd0, 16'sd0);
		// runs off the right edge of the grid
		cast_ray(16'sd253, 16'sd255, 16'sd300, 16'sd255);
		// starts outside the grid
		cast_ray(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768);
		cast_ray(16'sd32767, -16'sd1, 16'sd0, 16'sd0);
		// vertical and steep lines, and shallow lines in both directions
		cast_ray(16'sd0, 16'sd3, 16'sd0, 16'sd0);
		cast_ray(16'sd2, 16'sd1, 16'sd4, 16'sd7);
		cast_ray(16'sd7, 16'sd4, 16'sd1, 16'sd2);
		cast_ray(16'sd40, 16'sd40, 16'sd44, 16'sd41);

		for (int s = 0; s < 12; s++) begin
			ld = 1'b1;
			cols = 256;
			rows = 256;
			case (s)
				1: begin cols = 1; rows = 1; end
				2: cols = 0;
				3: begin cols = 511; rows = 511; end
				4: begin cols = 64; rows = 200; end
				5: ld = 1'b0;
				6: rows = 0;
				7: begin cols = 300; rows = 17; end
				9: begin cols = 2; rows = 255; end
				10: begin cols = $urandom_range(256, 1); rows = $urandom_range(256, 1); end
				default: ;
			endcase
			settle();
			case (s / 4)
				0: begin in_idle = 23; out_idle = 76; end
				1: begin in_idle = 76; out_idle = 23; end
				default: begin in_idle = 0; out_idle = 0; end
			endcase
			set_grid_cfg(ld, cols, rows);
			ec = (cols > GW) ? GW : cols;
			er = (rows > GH) ? GH : rows;
			goal = words_sent + SEG_WORDS;
			while (words_sent < goal) begin
				pick = $urandom_range(99);
				if (pick < 10) begin
					send_write(8'($urandom), 8'($urandom), 8'($urandom));
				end else begin
					if (pick < 62) begin
						// short ray near the area in use, start may sit just outside
						sx = 16'(int'($urandom_range(ec + 3)) - 2);
						sy = 16'(int'($urandom_range(er + 3)) - 2);
						ex = 16'(int'(sx) + int'($urandom_range(48)) - 24);
						ey = 16'(int'(sy) + int'($urandom_range(48)) - 24);
					end else if (pick < 72) begin
						sx = 16'($urandom_range(GW - 1));
						sy = 16'($urandom_range(GH - 1));
						ex = 16'($urandom);
						ey = 16'($urandom);
					end else if (pick < 84) begin
						sx = 16'($urandom);
						sy = 16'($urandom);
						ex = 16'($urandom);
						ey = 16'($urandom);
					end else if (pick < 93) begin
						sx = 16'($urandom_range(GW - 1));
						sy = 16'($urandom_range(GH - 1));
						ex = sx;
						ey = sy;
					end else begin
						sx = 16'($urandom_range(GW - 1));
						sy = 16'($urandom_range(GH - 1));
						ex = 16'($urandom_range(GW - 1));
						ey = 16'($urandom_range(GH - 1));
					end
					cast_ray(sx, sy, ex, ey);
				end
			end
		end

		settle();
		if (sb.due.size() != 0)
			sb.report($sformatf("%0d ray results never arrived", sb.due.size()));
		$display("sent %0d words over 12 grid settings and three pacing modes", words_sent);
		$display("checked %0d ray results, %0d of them stopped early", sb.rays_seen,
			sb.hits_seen);
		if (sb.mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
